// File: rtl/core/wsd_pkg.sv
`default_nettype none

package wsd_pkg;

  localparam logic [6:0] LenExt16 = 7'd126;
  localparam logic [6:0] LenExt64 = 7'd127;
  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;
  localparam logic [3:0] MaskBytes = 4'd4;

  typedef struct packed {
    logic       protocol_error;
    logic       message_end;
    logic       frame_end;
    logic       is_control;
    logic [3:0] message_opcode;
    logic       has_byte;
    logic [7:0] payload_byte;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/wsd_parser.sv
`default_nettype none

module wsd_parser (
  input  var logic          clk_i,
  input  var logic          rst_ni,
  input  var logic          in_vld_i,
  input  var logic [7:0]    in_byte_i,
  output var logic          res_vld_o,
  output var wsd_pkg::res_t res_o
);
  import wsd_pkg::*;

  localparam logic [2:0] PhHdr0    = 3'd0;
  localparam logic [2:0] PhHdr1    = 3'd1;
  localparam logic [2:0] PhExtLen  = 3'd2;
  localparam logic [2:0] PhMask    = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;
  localparam logic [2:0] PhLocked  = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic        fin_q, fin_d;
  logic [3:0]  fop_q, fop_d;
  logic        mask_q, mask_d;
  logic [3:0]  hbl_q, hbl_d;
  logic [63:0] left_q, left_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  midx_q, midx_d;
  logic        frag_q, frag_d;
  logic [3:0]  first_q, first_d;

  logic        after_len;
  logic        hdr_done;
  logic [6:0]  len7;
  logic [7:0]  key_byte;

  always_comb begin
    phase_d   = phase_q;
    fin_d     = fin_q;
    fop_d     = fop_q;
    mask_d    = mask_q;
    hbl_d     = hbl_q;
    left_d    = left_q;
    key_d     = key_q;
    midx_d    = midx_q;
    frag_d    = frag_q;
    first_d   = first_q;
    after_len = 1'b0;
    hdr_done  = 1'b0;
    res_vld_o = 1'b0;
    res_o     = '0;
    len7      = in_byte_i[6:0];
    key_byte  = mask_q ? key_q[{~midx_q, 3'b000} +: 8] : 8'h00;
    if (in_vld_i) begin
      unique case (phase_q)
        PhHdr0: begin
          if (|in_byte_i[6:4]) begin
            phase_d              = PhLocked;
            res_vld_o            = 1'b1;
            res_o.protocol_error = 1'b1;
          end else begin
            fin_d   = in_byte_i[7];
            fop_d   = in_byte_i[3:0];
            phase_d = PhHdr1;
          end
        end
        PhHdr1: begin
          mask_d = in_byte_i[7];
          if (len7 == LenExt16 || len7 == LenExt64) begin
            left_d  = '0;
            hbl_d   = (len7 == LenExt16) ? ExtBytes16 : ExtBytes64;
            phase_d = PhExtLen;
          end else begin
            left_d    = {57'd0, len7};
            after_len = 1'b1;
          end
        end
        PhExtLen: begin
          left_d = {left_q[55:0], in_byte_i};
          hbl_d  = hbl_q - 4'd1;
          if (hbl_d == 4'd0) begin
            after_len = 1'b1;
          end
        end
        PhMask: begin
          key_d = {key_q[23:0], in_byte_i};
          hbl_d = hbl_q - 4'd1;
          if (hbl_d == 4'd0) begin
            hdr_done = 1'b1;
          end
        end
        PhPayload: begin
          midx_d               = midx_q + 2'd1;
          left_d               = left_q - 64'd1;
          res_vld_o            = 1'b1;
          res_o.payload_byte   = in_byte_i ^ key_byte;
          res_o.has_byte       = 1'b1;
          res_o.is_control     = fop_q[3];
          res_o.message_opcode = fop_q[3] ? fop_q : first_q;
          res_o.frame_end      = (left_d == 64'd0);
          res_o.message_end    = (left_d == 64'd0) && fin_q;
          if (left_d == 64'd0) begin
            phase_d = PhHdr0;
          end
        end
        PhLocked: begin
          phase_d = PhLocked;
        end
        default: begin
          phase_d = PhLocked;
        end
      endcase
      if (after_len) begin
        if (mask_d) begin
          hbl_d   = MaskBytes;
          key_d   = '0;
          phase_d = PhMask;
        end else begin
          hdr_done = 1'b1;
        end
      end
      if (hdr_done) begin
        if (!fop_q[3]) begin
          if (!frag_q) begin
            first_d = fop_q;
          end
          frag_d = !fin_q;
        end
        midx_d = '0;
        if (left_d == 64'd0) begin
          phase_d              = PhHdr0;
          res_vld_o            = 1'b1;
          res_o.is_control     = fop_q[3];
          res_o.message_opcode = fop_q[3] ? fop_q : first_d;
          res_o.frame_end      = 1'b1;
          res_o.message_end    = fin_q;
        end else begin
          phase_d = PhPayload;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHdr0;
      fin_q   <= 1'b0;
      fop_q   <= '0;
      mask_q  <= 1'b0;
      hbl_q   <= '0;
      left_q  <= '0;
      key_q   <= '0;
      midx_q  <= '0;
      frag_q  <= 1'b0;
      first_q <= '0;
    end else begin
      phase_q <= phase_d;
      fin_q   <= fin_d;
      fop_q   <= fop_d;
      mask_q  <= mask_d;
      hbl_q   <= hbl_d;
      left_q  <= left_d;
      key_q   <= key_d;
      midx_q  <= midx_d;
      frag_q  <= frag_d;
      first_q <= first_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/wsd_out_buf.sv
`default_nettype none

module wsd_out_buf (
  input  var logic          clk_i,
  input  var logic          rst_ni,
  input  var logic          push_i,
  input  var wsd_pkg::res_t push_data_i,
  output var logic          space_o,
  output var logic          out_vld_o,
  input  var logic          out_rdy_i,
  output var wsd_pkg::res_t out_data_o
);
  import wsd_pkg::*;

  res_t out_q;
  res_t skid_q;
  logic out_vld_q;
  logic skid_vld_q;
  logic pop;

  assign pop        = out_vld_q && out_rdy_i;
  assign space_o    = !skid_vld_q;
  assign out_vld_o  = out_vld_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= push_i;
      end
    end else if (push_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/websocket_frame_deframer.sv
// websocket frame deframer, receive side after the opening handshake
// s_axis: one received stream byte per transaction in tdata[7:0]
// m_axis: zero or one result per input byte
//   tdata[7:0] unmasked payload byte (zero on an empty-frame marker)
//   tlast      last result of the frame
//   tuser      has_byte, message opcode, control flag, message end, protocol error
// header bytes produce no result; a zero-length frame produces one marker
// with has_byte low on its last header byte
// output: a result is registered in the output buffer before it is shown on m_axis
// throughput: one byte per cycle while s_axis_tready_o is high; the parser updates its
// state once per byte and its result goes to a two-entry output register
// receiver stall: the second output entry absorbs one more result, then
// s_axis_tready_o drops until m_axis takes a transaction
// reset clears the parser to expect a first header byte and empties the output;
// a frame with reserved bits set gives one protocol error result, after which
// bytes are still taken but no results appear until reset
`default_nettype none

module websocket_frame_deframer (
  input  var logic       clk_i,
  input  var logic       rst_ni,
  input  var logic       s_axis_tvalid_i,
  output var logic       s_axis_tready_o,
  input  var logic [7:0] s_axis_tdata_i,   // rx_byte
  output var logic       m_axis_tvalid_o,
  input  var logic       m_axis_tready_i,
  output var logic [7:0] m_axis_tdata_o,   // payload_byte
  output var logic       m_axis_tlast_o,   // frame_end
  output var logic [7:0] m_axis_tuser_o    // has_byte, message_opcode[3:0], is_control,
                                           // message_end, protocol_error
);
  import wsd_pkg::*;

  logic accept;
  logic res_vld;
  res_t res;
  res_t out_data;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  wsd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (accept),
    .in_byte_i (s_axis_tdata_i),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  wsd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_vld),
    .push_data_i (res),
    .space_o     (s_axis_tready_o),
    .out_vld_o   (m_axis_tvalid_o),
    .out_rdy_i   (m_axis_tready_i),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata_o = out_data.payload_byte;
  assign m_axis_tlast_o = out_data.frame_end;
  assign m_axis_tuser_o = {out_data.protocol_error, out_data.message_end,
                           out_data.is_control, out_data.message_opcode,
                           out_data.has_byte};

endmodule

`default_nettype wire

// File: rtl/core/wsd_checker.sv
`default_nettype none

module wsd_checker (
  input var logic       clk_i,
  input var logic       rst_ni,
  input var logic       s_axis_tvalid_i,
  input var logic       s_axis_tready_o,
  input var logic [7:0] s_axis_tdata_i,
  input var logic       m_axis_tvalid_o,
  input var logic       m_axis_tready_i,
  input var logic [7:0] m_axis_tdata_o,
  input var logic       m_axis_tlast_o,
  input var logic [7:0] m_axis_tuser_o
);

  // waiting input transaction holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && !s_axis_tready_o |=>
      s_axis_tvalid_i && $stable(s_axis_tdata_i))
    else $error("input changed while waiting");

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)
      && $stable(m_axis_tuser_o))
    else $error("output changed while stalled");

  // error result carries nothing else
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[7] |->
      m_axis_tdata_o == 8'h00 && m_axis_tuser_o[6:0] == 7'd0 && !m_axis_tlast_o)
    else $error("error result has other fields set");

  // empty-frame marker ends the frame with zero data
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] && !m_axis_tuser_o[7] |->
      m_axis_tlast_o && m_axis_tdata_o == 8'h00)
    else $error("empty-frame marker malformed");

  // nothing follows a delivered error
  a_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tuser_o[7] |=> !m_axis_tvalid_o)
    else $error("result after protocol error");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

// File: dv/websocket_frame_deframer_tb.sv
`timescale 1ns / 100ps

module websocket_frame_deframer_tb;
  import wsd_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned PhaseBytes = 185;
  localparam logic [3:0] ControlBase = 4'h8;
  localparam logic [3:0] OpCont = 4'h0;
  localparam logic [3:0] OpText = 4'h1;
  localparam logic [3:0] OpBinary = 4'h2;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing = 4'h9;

  typedef enum logic [2:0] {
    PhHdr0, PhHdr1, PhExtLen, PhMask, PhPayload, PhLocked
  } phase_e;

  typedef enum int {FormShort, FormExt16, FormExt64} len_form_e;

  class deframe_scoreboard;
    phase_e      phase;
    bit          fin;
    logic [3:0]  frame_op;
    bit          masked;
    logic [3:0]  hdr_left;
    logic [63:0] payload_left;
    logic [31:0] mask_key;
    logic [1:0]  mask_index;
    bit          in_frag;
    logic [3:0]  first_op;
    res_t        pending[$];
    int          mismatches;

    function new();
      phase = PhHdr0;
      fin = 0;
      frame_op = '0;
      masked = 0;
      hdr_left = '0;
      payload_left = '0;
      mask_key = '0;
      mask_index = '0;
      in_frag = 0;
      first_op = '0;
      mismatches = 0;
    endfunction

    function void push_result(logic [7:0] data, bit has, bit fend);
      res_t r;
      r = '0;
      r.payload_byte = data;
      r.has_byte = has;
      r.message_opcode = (frame_op >= ControlBase) ? frame_op : first_op;
      r.is_control = (frame_op >= ControlBase);
      r.frame_end = fend;
      r.message_end = fend && fin;
      pending.insert(pending.size(), r);
    endfunction

    function void header_done();
      if (frame_op < ControlBase) begin
        if (!in_frag) first_op = frame_op;
        in_frag = !fin;
      end
      mask_index = '0;
      if (payload_left == 0) begin
        phase = PhHdr0;
        push_result(8'h00, 1'b0, 1'b1);
      end else begin
        phase = PhPayload;
      end
    endfunction

    function void after_length();
      if (masked) begin
        hdr_left = MaskBytes;
        mask_key = '0;
        phase = PhMask;
      end else begin
        header_done();
      end
    endfunction

    function void take_byte(logic [7:0] b);
      res_t r;
      logic [7:0] v;
      case (phase)
        PhHdr0: begin
          if (b[6:4] != 3'b000) begin
            phase = PhLocked;
            r = '0;
            r.protocol_error = 1'b1;
            pending.insert(pending.size(), r);
          end else begin
            fin = b[7];
            frame_op = b[3:0];
            phase = PhHdr1;
          end
        end
        PhHdr1: begin
          masked = b[7];
          payload_left = '0;
          if (b[6:0] == LenExt16 || b[6:0] == LenExt64) begin
            hdr_left = (b[6:0] == LenExt16) ? ExtBytes16 : ExtBytes64;
            phase = PhExtLen;
          end else begin
            payload_left = 64'(b[6:0]);
            after_length();
          end
        end
        PhExtLen: begin
          payload_left = {payload_left[55:0], b};
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == 0) after_length();
        end
        PhMask: begin
          mask_key = {mask_key[23:0], b};
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == 0) header_done();
        end
        PhPayload: begin
          v = b;
          if (masked) v = b ^ 8'(mask_key >> (24 - 8 * int'(mask_index)));
          mask_index = mask_index + 2'd1;
          payload_left = payload_left - 64'd1;
          if (payload_left == 0) phase = PhHdr0;
          push_result(v, 1'b1, payload_left == 0);
        end
        default: phase = PhLocked;
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        $error("result with no pending expectation: %0h", got);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("has_byte", 8'(want.has_byte), 8'(got.has_byte));
      compare_field("message_opcode", 8'(want.message_opcode), 8'(got.message_opcode));
      compare_field("is_control", 8'(want.is_control), 8'(got.is_control));
      compare_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
      compare_field("message_end", 8'(want.message_end), 8'(got.message_end));
      compare_field("protocol_error", 8'(want.protocol_error), 8'(got.protocol_error));
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = '0;   // rx_byte
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;        // payload_byte
  logic       m_axis_tlast_o;        // frame_end
  logic [7:0] m_axis_tuser_o;        // has_byte, message_opcode[3:0], is_control,
                                     // message_end, protocol_error

  deframe_scoreboard sb = new();
  int unsigned send_idle = 29;
  int unsigned recv_idle = 81;
  int unsigned byte_count = 0;
  int unsigned cycle_count = 0;

  websocket_frame_deframer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver side: random stall, check each accepted transaction
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.payload_byte = m_axis_tdata_o;
      got.has_byte = m_axis_tuser_o[0];
      got.message_opcode = m_axis_tuser_o[4:1];
      got.is_control = m_axis_tuser_o[5];
      got.message_end = m_axis_tuser_o[6];
      got.protocol_error = m_axis_tuser_o[7];
      got.frame_end = m_axis_tlast_o;
      sb.check_result(got);
    end
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.take_byte(b);
    byte_count++;
  endtask

  task automatic send_frame(input bit fin, input logic [3:0] opcode, input bit masked,
                            input int unsigned len, input len_form_e form);
    logic [31:0] key;
    logic [63:0] len64;
    int i;
    key = $urandom;
    len64 = 64'(len);
    send_byte({fin, 3'b000, opcode});
    case (form)
      FormShort: send_byte({masked, 7'(len)});
      FormExt16: begin
        send_byte({masked, LenExt16});
        send_byte(len64[15:8]);
        send_byte(len64[7:0]);
      end
      default: begin
        send_byte({masked, LenExt64});
        for (i = 7; i >= 0; i--) send_byte(8'(len64 >> (8 * i)));
      end
    endcase
    if (masked) for (i = 0; i < 4; i++) send_byte(8'(key >> (24 - 8 * i)));
    for (i = 0; i < int'(len); i++) send_byte(8'($urandom));
  endtask

  task automatic send_random_frame();
    bit fin;
    logic [3:0] opcode;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) opcode = OpCont;
    else if (pick < 5) opcode = 4'($urandom_range(1, 2));
    else if (pick < 7) opcode = 4'($urandom_range(8, 10));
    else opcode = 4'($urandom_range(0, 15));
    fin = ($urandom_range(0, 99) < 60);
    pick = $urandom_range(0, 99);
    if (pick < 57)
      send_frame(fin, opcode, 1'($urandom_range(0, 1)), $urandom_range(0, 12), FormShort);
    else if (pick < 60)
      send_frame(fin, opcode, 1'($urandom_range(0, 1)), $urandom_range(100, 125), FormShort);
    else if (pick < 80)
      send_frame(fin, opcode, 1'($urandom_range(0, 1)), $urandom_range(0, 40), FormExt16);
    else if (pick < 83)
      send_frame(fin, opcode, 1'($urandom_range(0, 1)), $urandom_range(126, 150), FormExt16);
    else
      send_frame(fin, opcode, 1'($urandom_range(0, 1)), $urandom_range(0, 20), FormExt64);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int i;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames
    send_frame(1'b1, OpText, 1'b0, 0, FormShort);
    send_frame(1'b0, OpBinary, 1'b1, 3, FormShort);
    send_frame(1'b1, OpPing, 1'b1, 0, FormShort);
    send_frame(1'b1, OpCont, 1'b0, 2, FormExt16);
    send_frame(1'b1, OpClose, 1'b0, 0, FormExt64);
    send_frame(1'b0, OpText, 1'b0, 0, FormShort);
    send_frame(1'b1, OpBinary, 1'b0, 1, FormShort);

    send_idle = 29;
    recv_idle = 81;
    while (byte_count < PhaseBytes) send_random_frame();
    send_idle = 81;
    recv_idle = 29;
    while (byte_count < 2 * PhaseBytes) send_random_frame();
    send_idle = 0;
    recv_idle = 0;
    while (byte_count < 3 * PhaseBytes) send_random_frame();
    s_axis_tvalid_i <= 1'b0;
    drain();

    // reserved bits lock the parser; later bytes give nothing
    send_byte({1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)), 4'($urandom_range(0, 15))});
    send_byte({1'b1, 3'b000, OpText});
    send_byte(8'h00);
    for (i = 0; i < 6; i++) send_byte(8'($urandom));
    s_axis_tvalid_i <= 1'b0;
    drain();

    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
